// File: src/tbpr_pkg.sv
// ----------------------------------------------------------------------------
// tbpr_pkg
// Shared types and constants of the tile background pixel renderer.
// ----------------------------------------------------------------------------
package tbpr_pkg;

    localparam int VRAM_BYTES    = 8192;
    localparam int VRAM_AW       = $clog2(VRAM_BYTES);
    localparam int BANK_DEPTH    = VRAM_BYTES / 2;
    localparam int BANK_AW       = $clog2(BANK_DEPTH);
    localparam int SCREEN_WIDTH  = 160;
    localparam int SCREEN_HEIGHT = 144;

    localparam logic [8:0] SCREEN_W9 = 9'(SCREEN_WIDTH);
    localparam logic [8:0] SCREEN_H9 = 9'(SCREEN_HEIGHT);

    // upper address bits of the two tile maps (0x1800 / 0x1C00)
    localparam logic [1:0] MAP_TOP_BITS = 2'b11;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BG_ENABLE   = 3'd0,
        CFG_MAP_SELECT  = 3'd1,
        CFG_DATA_SELECT = 3'd2,
        CFG_SCROLL_H    = 3'd3,
        CFG_SCROLL_V    = 3'd4,
        CFG_PALETTE     = 3'd5
    } t_cfg_index;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_RENDER = 1'b1;

    // source of the shared video memory read address
    typedef enum logic [1:0] {
        ADR_MAP,
        ADR_ROW,
        ADR_HOLD
    } t_addr_sel;

    typedef struct packed {
        logic      clear;
        logic      in_ready;
        logic      load_out;
        t_addr_sel addr_sel;
    } t_ctrl_cmd;

    typedef struct packed {
        logic in_valid;
        logic render_ok;
        logic out_free;
        logic clear_last;
    } t_dp_status;

endpackage

// File: src/tbpr_in_if.sv
// ----------------------------------------------------------------------------
// tbpr_in_if
// Input channel: video memory writes and pixel render requests.
// ----------------------------------------------------------------------------
interface tbpr_in_if import tbpr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [VRAM_AW-1:0] vram_address;
    logic [7:0]         write_data;
    logic [7:0]         screen_column;
    logic [7:0]         screen_row;

    modport source (
        output valid, kind, vram_address, write_data, screen_column, screen_row,
        input  ready
    );
    modport sink (
        input  valid, kind, vram_address, write_data, screen_column, screen_row,
        output ready
    );
endinterface

// File: src/tbpr_out_if.sv
// ----------------------------------------------------------------------------
// tbpr_out_if
// Output channel: one rendered grey pixel with its screen position.
// ----------------------------------------------------------------------------
interface tbpr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] grey_shade;
    logic [7:0] out_column;
    logic [7:0] out_row;

    modport source (
        output valid, grey_shade, out_column, out_row,
        input  ready
    );
    modport sink (
        input  valid, grey_shade, out_column, out_row,
        output ready
    );
endinterface

// File: src/tile_background_pixel_renderer.sv
// ----------------------------------------------------------------------------
// tile_background_pixel_renderer
// Background pixel renderer over an 8 KiB tile video memory.
// ----------------------------------------------------------------------------
// Input channel i_in (valid/ready): kind 0 writes write_data to vram_address
// and gives no output word. kind 1 renders the pixel at
// screen_column/screen_row; it gives one word on o_out unless the background
// is disabled or the pixel lies off screen.
// A render reads the tile map, then both bit planes of the tile row at once
// (the memory is split into even and odd byte banks), then registers the
// grey byte. A new render can be accepted as the previous result is loaded
// into the output register; writes are accepted every cycle while idle.
// The output register lets the next word be accepted while a result waits;
// when o_out stalls, the pipeline holds its second render in the decode
// state and i_in.ready drops.
// Configuration (i_cfg_we, i_cfg_index, i_cfg_data) is to be written by the
// user only while the block is idle; the block itself does not enforce this.
// After reset the video memory is zeroed one word per cycle, with i_in.ready
// low. Configuration, clear address and output valid reset to zero.
// ----------------------------------------------------------------------------
module tile_background_pixel_renderer import tbpr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tbpr_in_if.sink               i_in,
    tbpr_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    tbpr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    tbpr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

// File: src/tbpr_ram.sv
// ----------------------------------------------------------------------------
// tbpr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tbpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/tbpr_ctrl.sv
// ----------------------------------------------------------------------------
// tbpr_ctrl
// Sequencer: memory clear after reset, then map read and tile row read
// for each render word.
// ----------------------------------------------------------------------------
module tbpr_ctrl import tbpr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_TILE,
        S_PIX
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   in_ready;
    logic   start_render;

    always_comb begin
        in_ready = (r_state == S_IDLE) || ((r_state == S_PIX) && i_status.out_free);
        start_render = in_ready && i_status.in_valid && i_status.render_ok;

        o_cmd.clear    = (r_state == S_CLEAR);
        o_cmd.in_ready = in_ready;
        o_cmd.load_out = (r_state == S_PIX) && i_status.out_free;
        o_cmd.addr_sel = ADR_HOLD;
        n_state        = r_state;

        case (r_state)
            S_CLEAR: begin
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.addr_sel = ADR_MAP;
                if (start_render) begin
                    n_state = S_TILE;
                end
            end
            S_TILE: begin
                o_cmd.addr_sel = ADR_ROW;
                n_state        = S_PIX;
            end
            S_PIX: begin
                // result leaves and the next word may enter at the same edge
                if (i_status.out_free) begin
                    o_cmd.addr_sel = ADR_MAP;
                    n_state        = start_render ? S_TILE : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: src/tbpr_datapath.sv
// ----------------------------------------------------------------------------
// tbpr_datapath
// Video memory in even/odd byte banks, configuration registers, address
// generation, pixel decode and the output register.
// ----------------------------------------------------------------------------
module tbpr_datapath import tbpr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tbpr_in_if.sink               i_in,
    tbpr_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_ctrl_cmd             i_cmd,
    output t_dp_status            o_status
);

    // configuration
    logic       r_bg_enable;
    logic       r_map_select;
    logic       r_data_select;
    logic [7:0] r_scroll_h;
    logic [7:0] r_scroll_v;
    logic [7:0] r_palette;

    // clear sweep
    logic [BANK_AW-1:0] r_clr_addr;

    // word in flight
    logic [7:0] r_col;
    logic [7:0] r_row;
    logic [2:0] r_fine_x;
    logic [2:0] r_fine_y;
    logic       r_map_odd;

    // output register
    logic       r_out_valid;
    logic [7:0] r_grey;
    logic [7:0] r_out_col;
    logic [7:0] r_out_row;

    logic               accept;
    logic               wr_item;
    logic [7:0]         bx;
    logic [7:0]         by;
    logic [VRAM_AW-1:0] map_addr;
    logic [7:0]         tile;
    logic [BANK_AW-1:0] row_word;
    logic [BANK_AW-1:0] raddr;
    logic [BANK_AW-1:0] r_raddr;
    logic [BANK_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic               we_even;
    logic               we_odd;
    logic [7:0]         rd_even;
    logic [7:0]         rd_odd;
    logic [2:0]         bit_sel;
    logic [1:0]         colour;
    logic [1:0]         shade;
    logic               out_free;

    assign accept   = i_cmd.in_ready && i_in.valid;
    assign wr_item  = accept && (i_in.kind == KIND_WRITE);
    assign out_free = !r_out_valid || o_out.ready;

    assign bx       = r_scroll_h + i_in.screen_column;
    assign by       = r_scroll_v + i_in.screen_row;
    assign map_addr = {MAP_TOP_BITS, r_map_select, by[7:3], bx[7:3]};

    // tile row address: unsigned from 0, or signed around 0x1000
    assign tile     = r_map_odd ? rd_odd : rd_even;
    assign row_word = {(!r_data_select && !tile[7]), tile, r_fine_y};

    always_comb begin
        case (i_cmd.addr_sel)
            ADR_MAP: raddr = map_addr[VRAM_AW-1:1];
            ADR_ROW: raddr = row_word;
            default: raddr = r_raddr;
        endcase
    end

    assign waddr   = i_cmd.clear ? r_clr_addr : i_in.vram_address[VRAM_AW-1:1];
    assign wdata   = i_cmd.clear ? 8'h00 : i_in.write_data;
    assign we_even = i_cmd.clear || (wr_item && !i_in.vram_address[0]);
    assign we_odd  = i_cmd.clear || (wr_item && i_in.vram_address[0]);

    tbpr_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_bank_even (
        .i_clk   (i_clk),
        .i_we    (we_even),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_even)
    );

    tbpr_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_bank_odd (
        .i_clk   (i_clk),
        .i_we    (we_odd),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_odd)
    );

    // even bank holds the low plane, odd bank the high plane
    assign bit_sel = 3'd7 - r_fine_x;
    assign colour  = {rd_odd[bit_sel], rd_even[bit_sel]};
    assign shade   = ~r_palette[{colour, 1'b0} +: 2];

    always_comb begin
        o_status.in_valid   = i_in.valid;
        o_status.render_ok  = (i_in.kind == KIND_RENDER) && r_bg_enable
                              && ({1'b0, i_in.screen_column} < SCREEN_W9)
                              && ({1'b0, i_in.screen_row} < SCREEN_H9);
        o_status.out_free   = out_free;
        o_status.clear_last = (r_clr_addr == {BANK_AW{1'b1}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg_enable   <= 1'b0;
            r_map_select  <= 1'b0;
            r_data_select <= 1'b0;
            r_scroll_h    <= 8'h00;
            r_scroll_v    <= 8'h00;
            r_palette     <= 8'h00;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BG_ENABLE:   r_bg_enable   <= i_cfg_data[0];
                CFG_MAP_SELECT:  r_map_select  <= i_cfg_data[0];
                CFG_DATA_SELECT: r_data_select <= i_cfg_data[0];
                CFG_SCROLL_H:    r_scroll_h    <= i_cfg_data[7:0];
                CFG_SCROLL_V:    r_scroll_v    <= i_cfg_data[7:0];
                CFG_PALETTE:     r_palette     <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_raddr <= raddr;
        if (accept) begin
            r_col     <= i_in.screen_column;
            r_row     <= i_in.screen_row;
            r_fine_x  <= bx[2:0];
            r_fine_y  <= by[2:0];
            r_map_odd <= bx[3];
        end
        if (i_cmd.load_out) begin
            r_grey    <= {4{shade}};
            r_out_col <= r_col;
            r_out_row <= r_row;
        end
    end

    assign i_in.ready       = i_cmd.in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.grey_shade = r_grey;
    assign o_out.out_column = r_out_col;
    assign o_out.out_row    = r_out_row;

endmodule

// File: tb/tile_background_pixel_renderer_test.sv
// ----------------------------------------------------------------------------
// tile_background_pixel_renderer_test
// Self-checking bench for the background pixel renderer. A driver feeds
// video memory writes and pixel render requests from a queue. A local model
// of the video memory and registers predicts every grey pixel word. A
// monitor compares each output word with the oldest prediction. Phases vary
// the register settings, the sender gaps and the receiver stalls, and one
// phase holds the receiver off long enough to back up the input.
// ----------------------------------------------------------------------------
module tile_background_pixel_renderer_test import tbpr_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int PHASE_ITEMS     = 245;
    localparam int RANDOM_PHASES   = 8;
    localparam int PRESSURE_PHASE  = 4;
    localparam int SETTLE_CYCLES   = 8;
    localparam int MAX_REPORTS     = 10;

    // indexes past the register list, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam logic [VRAM_AW-1:0] MAP_LO_BASE = 13'h1800;
    localparam logic [VRAM_AW-1:0] MAP_HI_BASE = 13'h1C00;

    typedef struct packed {
        logic               kind;
        logic [VRAM_AW-1:0] addr;
        logic [7:0]         data;
        logic [7:0]         col;
        logic [7:0]         row;
    } t_pixel_req;

    typedef struct packed {
        logic [7:0] grey;
        logic [7:0] col;
        logic [7:0] row;
    } t_pixel_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  hold_off = 1'b0;

    tbpr_in_if  req_bus ();
    tbpr_out_if pix_bus ();

    tile_background_pixel_renderer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (req_bus),
        .o_out       (pix_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // model of the block
    logic       bg_enable;
    logic       map_sel;
    logic       data_sel;
    logic [7:0] hscroll;
    logic [7:0] vscroll;
    logic [7:0] palette;
    logic [7:0] vram_image [VRAM_BYTES];

    t_pixel_req  request_queue [$];
    t_pixel_word pending_pixels [$];
    t_pixel_req  cur_req;

    int queued_reqs   = 0;
    int accepted_reqs = 0;
    int error_count   = 0;
    int idle_cycles   = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int phase_num     = -1;

    always #4 i_clk = ~i_clk;

    function automatic logic [VRAM_AW-1:0] map_entry_addr(logic [7:0] bx, logic [7:0] by);
        return (map_sel ? MAP_HI_BASE : MAP_LO_BASE) + VRAM_AW'({by[7:3], bx[7:3]});
    endfunction

    function automatic logic [VRAM_AW-1:0] tile_row_addr(logic [7:0] tile, logic [2:0] line);
        int base;
        if (data_sel) begin
            base = int'(tile) * 16;
        end else begin
            base = 'h1000 + int'($signed(tile)) * 16;
        end
        return VRAM_AW'((base + int'(line) * 2) & (VRAM_BYTES - 1));
    endfunction

    function automatic logic [7:0] predict_grey(logic [7:0] col, logic [7:0] row);
        logic [7:0]         bx;
        logic [7:0]         by;
        logic [7:0]         tile;
        logic [7:0]         lo;
        logic [7:0]         hi;
        logic [VRAM_AW-1:0] ra;
        logic [2:0]         bit_pos;
        logic [1:0]         colour;
        logic [1:0]         shade;
        bx = col + hscroll;
        by = row + vscroll;
        tile = vram_image[map_entry_addr(bx, by)];
        ra = tile_row_addr(tile, by[2:0]);
        lo = vram_image[ra];
        hi = vram_image[ra + 1'b1];
        bit_pos = 3'd7 - bx[2:0];
        colour = {hi[bit_pos], lo[bit_pos]};
        shade = ~palette[{colour, 1'b0} +: 2];
        return {4{shade}};
    endfunction

    function automatic void apply_request(t_pixel_req r);
        t_pixel_word w;
        if (r.kind == KIND_WRITE) begin
            vram_image[r.addr] = r.data;
        end else if (bg_enable && r.col < SCREEN_WIDTH && r.row < SCREEN_HEIGHT) begin
            w.grey = predict_grey(r.col, r.row);
            w.col  = r.col;
            w.row  = r.row;
            pending_pixels.push_back(w);
        end
    endfunction

    function automatic void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        case (idx)
            CFG_BG_ENABLE:   bg_enable = val[0];
            CFG_MAP_SELECT:  map_sel   = val[0];
            CFG_DATA_SELECT: data_sel  = val[0];
            CFG_SCROLL_H:    hscroll   = val;
            CFG_SCROLL_V:    vscroll   = val;
            CFG_PALETTE:     palette   = val;
            default: ;
        endcase
    endfunction

    function automatic void report_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("ERROR: %s", msg);
        end
    endfunction

    function automatic void check_pixel(t_pixel_word got);
        t_pixel_word exp;
        if (pending_pixels.size() == 0) begin
            report_error($sformatf("unexpected word grey=%02h col=%0d row=%0d",
                                   got.grey, got.col, got.row));
        end else begin
            exp = pending_pixels.pop_front();
            if (got.grey !== exp.grey || got.col !== exp.col || got.row !== exp.row) begin
                report_error($sformatf({"expected grey=%02h col=%0d row=%0d, ",
                                        "got grey=%02h col=%0d row=%0d"},
                                       exp.grey, exp.col, exp.row, got.grey, got.col, got.row));
            end
        end
    endfunction

    function automatic t_pixel_req write_req(logic [VRAM_AW-1:0] a, logic [7:0] d);
        t_pixel_req r;
        r.kind = KIND_WRITE;
        r.addr = a;
        r.data = d;
        r.col  = 8'($urandom);
        r.row  = 8'($urandom);
        return r;
    endfunction

    function automatic t_pixel_req render_req(logic [7:0] col, logic [7:0] row);
        t_pixel_req r;
        r.kind = KIND_RENDER;
        r.addr = VRAM_AW'($urandom);
        r.data = 8'($urandom);
        r.col  = col;
        r.row  = row;
        return r;
    endfunction

    function automatic void queue_req(t_pixel_req r);
        request_queue.push_back(r);
        queued_reqs++;
    endfunction

    // map entry, both planes of the tile row, then a few pixels of that row
    function automatic void queue_tile_sequence();
        logic [7:0]         col;
        logic [7:0]         row;
        logic [7:0]         bx;
        logic [7:0]         by;
        logic [7:0]         tile;
        logic [VRAM_AW-1:0] ra;
        int                 n;
        col  = 8'($urandom_range(SCREEN_WIDTH - 1));
        row  = 8'($urandom_range(SCREEN_HEIGHT - 1));
        bx   = col + hscroll;
        by   = row + vscroll;
        tile = 8'($urandom);
        ra   = tile_row_addr(tile, by[2:0]);
        queue_req(write_req(map_entry_addr(bx, by), tile));
        queue_req(write_req(ra, 8'($urandom)));
        queue_req(write_req(ra + 1'b1, 8'($urandom)));
        n = $urandom_range(1, 4);
        repeat (n) queue_req(render_req(col - bx[2:0] + 8'($urandom_range(7)), row));
    endfunction

    function automatic void queue_random_item();
        logic [VRAM_AW-1:0] a;
        logic [7:0]         col;
        logic [7:0]         row;
        if ($urandom_range(99) < 40) begin
            case ($urandom_range(9))
                0, 1, 2, 3: a = MAP_LO_BASE + VRAM_AW'($urandom_range('h7FF));
                9:          a = VRAM_AW'($urandom);
                default:    a = VRAM_AW'($urandom_range('h17FF));
            endcase
            queue_req(write_req(a, 8'($urandom)));
        end else begin
            col = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(SCREEN_WIDTH - 1));
            row = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(SCREEN_HEIGHT - 1));
            queue_req(render_req(col, row));
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        set_reg(idx, val);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_regs(input logic [7:0] en, input logic [7:0] msel,
                                input logic [7:0] dsel, input logic [7:0] sx,
                                input logic [7:0] sy, input logic [7:0] pal);
        write_reg(CFG_BG_ENABLE, en);
        write_reg(CFG_MAP_SELECT, msel);
        write_reg(CFG_DATA_SELECT, dsel);
        write_reg(CFG_SCROLL_H, sx);
        write_reg(CFG_SCROLL_V, sy);
        write_reg(CFG_PALETTE, pal);
    endtask

    // all words accepted and all pixels out, then room for a trailing write
    task automatic wait_idle();
        while (accepted_reqs != queued_reqs || pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                apply_request(cur_req);
                accepted_reqs++;
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_req = request_queue.pop_front();
                    req_bus.valid         <= 1'b1;
                    req_bus.kind          <= cur_req.kind;
                    req_bus.vram_address  <= cur_req.addr;
                    req_bus.write_data    <= cur_req.data;
                    req_bus.screen_column <= cur_req.col;
                    req_bus.screen_row    <= cur_req.row;
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_bus.ready <= 1'b0;
        end else begin
            if (pix_bus.valid && pix_bus.ready) begin
                check_pixel({pix_bus.grey_shade, pix_bus.out_column, pix_bus.out_row});
            end
            pix_bus.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        wait (phase_num == PRESSURE_PHASE);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (pix_bus.valid && pix_bus.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int start;
        i_rst_n               = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        req_bus.valid         = 1'b0;
        req_bus.kind          = KIND_WRITE;
        req_bus.vram_address  = '0;
        req_bus.write_data    = '0;
        req_bus.screen_column = '0;
        req_bus.screen_row    = '0;
        pix_bus.ready         = 1'b0;
        for (int i = 0; i < VRAM_BYTES; i++) vram_image[i] = 8'h00;
        bg_enable = 1'b0;
        map_sel   = 1'b0;
        data_sel  = 1'b0;
        hscroll   = 8'h00;
        vscroll   = 8'h00;
        palette   = 8'h00;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // background off: renders give nothing
        program_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_req(render_req(8'd0, 8'd0));
        queue_req(render_req(8'd159, 8'd143));
        queue_req(write_req(13'h1000, 8'hAA));
        wait_idle();

        // signed tiles, low map, no scroll
        program_regs(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'hE4);
        queue_req(write_req(13'h1800, 8'h80));     // tile -128
        queue_req(write_req(13'h0800, 8'hFF));
        queue_req(write_req(13'h0801, 8'h00));
        queue_req(render_req(8'd0, 8'd0));
        queue_req(render_req(8'd7, 8'd0));
        queue_req(write_req(13'h1A33, 8'h7F));     // tile +127 under the last pixel
        queue_req(write_req(13'h17FE, 8'h01));
        queue_req(write_req(13'h17FF, 8'h01));
        queue_req(render_req(8'd159, 8'd143));
        queue_req(render_req(8'd160, 8'd0));       // off screen
        queue_req(render_req(8'd0, 8'd144));
        queue_req(render_req(8'd255, 8'd255));
        queue_req(write_req(13'h1FFF, 8'hFF));
        queue_req(write_req(13'h0000, 8'h00));
        queue_req(render_req(8'd8, 8'd8));
        wait_idle();

        // unsigned tiles, high map, scroll wrap; wide values and spare indexes
        program_regs(8'hFF, 8'hFF, 8'h03, 8'hFF, 8'hFF, 8'h1B);
        write_reg(CFG_SPARE_LO, 8'($urandom));
        write_reg(CFG_SPARE_HI, 8'($urandom));
        queue_req(write_req(13'h1C00, 8'hFF));
        queue_req(write_req(13'h0FF0, 8'h80));
        queue_req(write_req(13'h0FF1, 8'h80));
        queue_req(render_req(8'd1, 8'd1));
        queue_req(render_req(8'd0, 8'd0));
        queue_req(render_req(8'd159, 8'd143));
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                    program_regs(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'hE4);
                end
                1: begin
                    send_idle_pct = 88; recv_stall_pct = 0;
                    program_regs(8'h01, 8'h01, 8'h01, 8'hFF, 8'hFF, 8'hFF);
                end
                2: begin
                    send_idle_pct = 0;  recv_stall_pct = 88;
                    program_regs(8'h01, 8'h00, 8'h01, 8'($urandom), 8'($urandom), 8'h00);
                end
                3: begin
                    send_idle_pct = 23; recv_stall_pct = 23;
                    program_regs(8'h01, 8'h01, 8'h00, 8'($urandom), 8'($urandom),
                                 8'($urandom));
                end
                5: begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                    program_regs(8'h00, 8'($urandom), 8'($urandom), 8'($urandom),
                                 8'($urandom), 8'($urandom));
                end
                default: begin
                    send_idle_pct  = (p == 6) ? 88 : (p == 7) ? 0 : 0;
                    recv_stall_pct = (p == 7) ? 88 : 0;
                    program_regs(8'h01, 8'($urandom), 8'($urandom), 8'($urandom),
                                 8'($urandom), 8'($urandom));
                end
            endcase
            phase_num = p;
            start = queued_reqs;
            while (queued_reqs - start < PHASE_ITEMS) begin
                if ($urandom_range(1) == 0) begin
                    queue_tile_sequence();
                end else begin
                    queue_random_item();
                end
            end
            wait_idle();
        end

        if (error_count == 0 && pending_pixels.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
